// ===== sv/fpc_pkg.sv =====
// Shared types and constants for the frame progress checker.
// No dependencies; used by every module of the block.
`default_nettype none

package fpc_pkg;

    // Proof status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_PASSED   = 2'd1;
    localparam logic [1:0] ST_DEAD     = 2'd2;
    localparam logic [1:0] ST_BAD_STEP = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REQUIRED_STEPS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STAGNANT_LIMIT = 2'd1;

    // Field widths
    localparam int unsigned RASTER_BITS = 9;
    localparam int unsigned STEPS_BITS  = 4;
    localparam int unsigned LIMIT_BITS  = 17;
    localparam int unsigned CFG_DATA_BITS = LIMIT_BITS;

    // Reset values of the configuration registers
    localparam logic [STEPS_BITS-1:0] REQUIRED_STEPS_RST = 4'd3;
    localparam logic [LIMIT_BITS-1:0] STAGNANT_LIMIT_RST = 17'h10000;

    // Current configuration as seen by the tracker
    typedef struct packed {
        logic [STEPS_BITS-1:0] required_steps;
        logic [LIMIT_BITS-1:0] stagnant_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/fpc_cfg_regs.sv =====
// Configuration registers of the frame progress checker.
// Depends on fpc_pkg for register indexes, reset values and the t_cfg struct.
`default_nettype none

module fpc_cfg_regs (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [fpc_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire [fpc_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output fpc_pkg::t_cfg                         o_cfg
);

    fpc_pkg::t_cfg r_cfg;

    // Always take a configuration word
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register, drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.required_steps <= fpc_pkg::REQUIRED_STEPS_RST;
            r_cfg.stagnant_limit <= fpc_pkg::STAGNANT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpc_pkg::CFG_REQUIRED_STEPS: begin
                    r_cfg.required_steps <= i_cfg_data[fpc_pkg::STEPS_BITS-1:0];
                end
                fpc_pkg::CFG_STAGNANT_LIMIT: begin
                    r_cfg.stagnant_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/fpc_tracker.sv =====
// Proof state and per-word update logic of the frame progress checker.
// Depends on fpc_pkg for status codes, widths and the t_cfg struct.
`default_nettype none

module fpc_tracker #(
    parameter int unsigned FRAME_COUNT_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire [fpc_pkg::RASTER_BITS-1:0]      i_raster_line,
    input  wire [FRAME_COUNT_BITS-1:0]          i_frame_count,
    input  wire                                 i_restart,
    input  wire fpc_pkg::t_cfg                  i_cfg,
    output logic [1:0]                          o_status,
    output logic [fpc_pkg::STEPS_BITS-1:0]      o_steps_verified
);

    localparam int unsigned RB = fpc_pkg::RASTER_BITS;
    localparam int unsigned SB = fpc_pkg::STEPS_BITS;
    localparam int unsigned LB = fpc_pkg::LIMIT_BITS;

    logic                        r_phase_synced, n_phase_synced;
    logic                        r_have_base, n_have_base;
    logic [RB-1:0]               r_base_raster, n_base_raster;
    logic [LB-1:0]               r_stagnant_run, n_stagnant_run;
    logic [FRAME_COUNT_BITS-1:0] r_base_frame, n_base_frame;
    logic [SB-1:0]               r_step_count, n_step_count;
    logic [1:0]                  r_status, n_status;

    logic [FRAME_COUNT_BITS-1:0] frame_diff;
    logic [SB-1:0]               need_steps;
    logic [LB-1:0]               limit_eff;
    logic [SB-1:0]               step_inc;
    logic [LB-1:0]               run_inc;
    logic                        is_wrap;

    // Zero limits act as one
    assign need_steps = (i_cfg.required_steps == '0) ? SB'(1) : i_cfg.required_steps;
    assign limit_eff  = (i_cfg.stagnant_limit == '0) ? LB'(1) : i_cfg.stagnant_limit;
    assign frame_diff = i_frame_count - r_base_frame;
    assign step_inc   = r_step_count + SB'(1);
    assign run_inc    = (r_stagnant_run == {LB{1'b1}}) ? r_stagnant_run
                                                       : r_stagnant_run + LB'(1);
    // Wrap: base high half, sample low half
    assign is_wrap    = r_base_raster[RB-1] && !i_raster_line[RB-1];

    // Next proof state for the word in the input register
    always_comb begin
        n_phase_synced = r_phase_synced;
        n_have_base    = r_have_base;
        n_base_raster  = r_base_raster;
        n_stagnant_run = r_stagnant_run;
        n_base_frame   = r_base_frame;
        n_step_count   = r_step_count;
        n_status       = r_status;
        if (i_restart) begin
            n_phase_synced = 1'b0;
            n_step_count   = '0;
            n_stagnant_run = '0;
            n_status       = fpc_pkg::ST_RUNNING;
            n_have_base    = 1'b1;
            n_base_raster  = i_raster_line;
        end else if (r_status == fpc_pkg::ST_RUNNING) begin
            if (!r_have_base) begin
                n_have_base    = 1'b1;
                n_base_raster  = i_raster_line;
                n_stagnant_run = '0;
            end else if (is_wrap) begin
                // Frame wrap: sync on the first, check unit step after that
                n_have_base    = 1'b0;
                n_stagnant_run = '0;
                if (!r_phase_synced) begin
                    n_phase_synced = 1'b1;
                    n_base_frame   = i_frame_count;
                end else if (frame_diff == FRAME_COUNT_BITS'(1)) begin
                    n_step_count = step_inc;
                    n_base_frame = i_frame_count;
                    if (step_inc >= need_steps) begin
                        n_status = fpc_pkg::ST_PASSED;
                    end
                end else begin
                    n_status = fpc_pkg::ST_BAD_STEP;
                end
            end else begin
                // Count unchanged samples, fail once the run reaches the limit
                if (i_raster_line == r_base_raster) begin
                    n_stagnant_run = run_inc;
                    if (run_inc >= limit_eff) begin
                        n_status = fpc_pkg::ST_DEAD;
                    end
                end else begin
                    n_stagnant_run = '0;
                end
                n_base_raster = i_raster_line;
            end
        end
    end

    assign o_status         = n_status;
    assign o_steps_verified = n_step_count;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_synced <= 1'b0;
            r_have_base    <= 1'b0;
            r_base_raster  <= '0;
            r_stagnant_run <= '0;
            r_base_frame   <= '0;
            r_step_count   <= '0;
            r_status       <= fpc_pkg::ST_RUNNING;
        end else if (i_en) begin
            r_phase_synced <= n_phase_synced;
            r_have_base    <= n_have_base;
            r_base_raster  <= n_base_raster;
            r_stagnant_run <= n_stagnant_run;
            r_base_frame   <= n_base_frame;
            r_step_count   <= n_step_count;
            r_status       <= n_status;
        end
    end

    // A final status holds until restart
    a_final_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_restart && r_status != fpc_pkg::ST_RUNNING)
        |=> (r_status == $past(r_status) && r_step_count == $past(r_step_count)))
        else $error("final status changed without restart");

    // Restart starts a new proof with this sample as base
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_restart)
        |=> (r_have_base && !r_phase_synced && r_step_count == '0
             && r_status == fpc_pkg::ST_RUNNING))
        else $error("restart did not clear progress");

    // Steps are only counted after synchronization
    a_steps_need_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_phase_synced |-> r_step_count == '0)
        else $error("steps counted before synchronizing wrap");

endmodule

`default_nettype wire

// ===== sv/frame_progress_checker_core.sv =====
// Frame progress checker: input register, one update stage, result register; a word
// moves on when the result register is free, one word per cycle while results drain.
// The input side keeps taking words while a result waits, until the input register
// is also held. Synchronous active-low reset clears the proof state to running with
// no base sample; required_steps resets to 3 and stagnant_limit to 65536.
// Depends on fpc_pkg, fpc_cfg_regs and fpc_tracker.
`default_nettype none

module frame_progress_checker_core #(
    parameter int unsigned FRAME_COUNT_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [fpc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire [fpc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // input words
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire [fpc_pkg::RASTER_BITS-1:0]      i_raster_line,
    input  wire [FRAME_COUNT_BITS-1:0]          i_frame_count,
    input  wire                                 i_restart,
    // result words
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [1:0]                          o_status,
    output logic [fpc_pkg::STEPS_BITS-1:0]      o_steps_verified
);

    fpc_pkg::t_cfg cfg;

    logic                                r_in_valid;
    logic [fpc_pkg::RASTER_BITS-1:0]     r_raster;
    logic [FRAME_COUNT_BITS-1:0]         r_frame;
    logic                                r_restart;
    logic                                r_out_valid;
    logic [1:0]                          r_status;
    logic [fpc_pkg::STEPS_BITS-1:0]      r_steps;
    logic                                advance;
    logic [1:0]                          nxt_status;
    logic [fpc_pkg::STEPS_BITS-1:0]      nxt_steps;

    fpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Move the held word into the result register when it is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    fpc_tracker #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_tracker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (advance),
        .i_raster_line    (r_raster),
        .i_frame_count    (r_frame),
        .i_restart        (r_restart),
        .i_cfg            (cfg),
        .o_status         (nxt_status),
        .o_steps_verified (nxt_steps)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_raster  <= i_raster_line;
            r_frame   <= i_frame_count;
            r_restart <= i_restart;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= nxt_status;
            r_steps  <= nxt_steps;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_steps_verified = r_steps;

    // Input stalls only while a word is held
    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a held word");

    // A word that advances always produces a result next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced word produced no result");

endmodule

`default_nettype wire
